@@ hw/rtl/kcd_pkg.sv @@
// Shared types, constants and helpers for the key click detector.
package kcd_pkg;

  localparam int NUM_KEYS_DEF = 3;
  localparam int LEVEL_W      = 3;
  localparam int KEY_INDEX_W  = 2;
  localparam int FLAG_SEL_W   = 3;
  localparam int FLAG_W       = 7;
  localparam int DIV_W        = 8;
  localparam int TIMER_W      = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  // Opcodes of a request beat.
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  // Flag selects; all but FLAG_NONE are also the bit positions in the flag word.
  localparam logic [FLAG_SEL_W-1:0] FLAG_HOLD      = 3'd0;
  localparam logic [FLAG_SEL_W-1:0] FLAG_DOWN      = 3'd1;
  localparam logic [FLAG_SEL_W-1:0] FLAG_UP        = 3'd2;
  localparam logic [FLAG_SEL_W-1:0] FLAG_SINGLE    = 3'd3;
  localparam logic [FLAG_SEL_W-1:0] FLAG_DOUBLE    = 3'd4;
  localparam logic [FLAG_SEL_W-1:0] FLAG_LONG      = 3'd5;
  localparam logic [FLAG_SEL_W-1:0] FLAG_LONG_LONG = 3'd6;
  localparam logic [FLAG_SEL_W-1:0] FLAG_NONE      = 3'd7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_DIVIDER   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_GAP_TICKS = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERY_LONG_TICKS  = 2'd3;

  localparam logic [DIV_W-1:0]   SAMPLE_DIVIDER_RST   = 8'd20;
  localparam logic [TIMER_W-1:0] LONG_PRESS_TICKS_RST = 16'd2000;
  localparam logic [TIMER_W-1:0] DOUBLE_GAP_TICKS_RST = 16'd200;
  localparam logic [TIMER_W-1:0] VERY_LONG_TICKS_RST  = 16'd100;

  typedef logic [FLAG_W-1:0] flags_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_PRESSED  = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SECOND   = 3'd3,
    PH_LONG     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [DIV_W-1:0]   sample_divider;
    logic [TIMER_W-1:0] long_press_ticks;
    logic [TIMER_W-1:0] double_gap_ticks;
    logic [TIMER_W-1:0] very_long_ticks;
  } cfg_t;

  typedef struct packed {
    logic                   tick;
    logic                   sample;
    logic                   check;
    logic [KEY_INDEX_W-1:0] key_index;
    logic [FLAG_SEL_W-1:0]  flag_select;
  } lane_ctrl_t;

  // One-hot mask of the selected flag; the unused select gives no bit.
  function automatic flags_t flag_mask(input logic [FLAG_SEL_W-1:0] sel);
    flags_t m;
    m = '0;
    if (sel != FLAG_NONE) begin
      m[sel] = 1'b1;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/kcd_in_if.sv @@
// Request channel of the key click detector.
interface kcd_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [kcd_pkg::LEVEL_W-1:0]      key_levels;
  logic [kcd_pkg::KEY_INDEX_W-1:0]  key_index;
  logic [kcd_pkg::FLAG_SEL_W-1:0]   flag_select;

  modport source (output valid, opcode, key_levels, key_index, flag_select, input ready);
  modport sink   (input valid, opcode, key_levels, key_index, flag_select, output ready);
endinterface

@@ hw/rtl/kcd_out_if.sv @@
// Response channel of the key click detector.
interface kcd_out_if;
  logic valid;
  logic ready;
  logic flag_hit;

  modport source (output valid, flag_hit, input ready);
  modport sink   (input valid, flag_hit, output ready);
endinterface

@@ hw/rtl/kcd_key_lane.sv @@
// One key lane: level history, click phase machine, press timer and event flags.
module kcd_key_lane #(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  kcd_pkg::lane_ctrl_t ctrl,
  input  kcd_pkg::cfg_t       cfg,
  input  logic                level,
  output kcd_pkg::flags_t     flags
);
  import kcd_pkg::*;

  logic                cur_level, cur_level_next;
  logic                prev_level, prev_level_next;
  phase_t              phase, phase_next;
  logic [TIMER_W-1:0]  timer, timer_next, timer_dec;
  flags_t              event_flags, event_flags_next;
  logic                mine;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level   <= 1'b0;
      prev_level  <= 1'b0;
      phase       <= PH_IDLE;
      timer       <= '0;
      event_flags <= '0;
    end else begin
      cur_level   <= cur_level_next;
      prev_level  <= prev_level_next;
      phase       <= phase_next;
      timer       <= timer_next;
      event_flags <= event_flags_next;
    end
  end

  assign timer_dec = (timer != '0) ? timer - TIMER_W'(1) : timer;
  assign mine      = ctrl.check && (int'(ctrl.key_index) == LANE);

  always_comb begin
    cur_level_next   = cur_level;
    prev_level_next  = prev_level;
    phase_next       = phase;
    timer_next       = ctrl.tick ? timer_dec : timer;
    event_flags_next = event_flags;

    if (ctrl.sample) begin
      prev_level_next             = cur_level;
      cur_level_next              = level;
      event_flags_next[FLAG_HOLD] = level;
      if (level && !cur_level) begin
        event_flags_next[FLAG_DOWN] = 1'b1;
      end
      if (!level && cur_level) begin
        event_flags_next[FLAG_UP] = 1'b1;
      end
      case (phase)
        PH_IDLE: begin
          if (level) begin
            phase_next = PH_PRESSED;
            timer_next = cfg.long_press_ticks;
          end
        end
        PH_PRESSED: begin
          if (!level) begin
            phase_next = PH_RELEASED;
            timer_next = cfg.double_gap_ticks;
          end else if (timer_dec == '0) begin
            phase_next = PH_LONG;
            timer_next = cfg.very_long_ticks;
          end
        end
        PH_RELEASED: begin
          if (level) begin
            event_flags_next[FLAG_DOUBLE] = 1'b1;
            phase_next = PH_SECOND;
          end else if (timer_dec == '0) begin
            event_flags_next[FLAG_SINGLE] = 1'b1;
            phase_next = PH_IDLE;
          end
        end
        PH_SECOND: begin
          if (!level) begin
            phase_next = PH_IDLE;
          end
        end
        PH_LONG: begin
          if (!level) begin
            event_flags_next[FLAG_LONG] = 1'b1;
            phase_next = PH_IDLE;
          end else if (timer_dec == '0) begin
            event_flags_next[FLAG_LONG_LONG] = 1'b1;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end

    // A check clears the flag it reads, but the hold flag follows the level.
    if (mine && ctrl.flag_select != FLAG_HOLD) begin
      event_flags_next = event_flags & ~flag_mask(ctrl.flag_select);
    end
  end

  assign flags = event_flags;

  a_check_clears: assert property (@(posedge clk) disable iff (rst)
    mine && ctrl.flag_select != FLAG_HOLD |=>
      (event_flags & $past(flag_mask(ctrl.flag_select))) == '0)
    else $error("checked flag was not cleared");

  a_down_edge: assert property (@(posedge clk) disable iff (rst)
    ctrl.sample && level && !cur_level |=> event_flags[FLAG_DOWN])
    else $error("press edge did not raise the down flag");

  a_hold_follows: assert property (@(posedge clk) disable iff (rst)
    ctrl.sample |=> event_flags[FLAG_HOLD] == cur_level)
    else $error("hold flag does not follow the sampled level");

  a_level_history: assert property (@(posedge clk) disable iff (rst)
    ctrl.sample |=> prev_level == $past(cur_level))
    else $error("level history did not shift on a sample");

endmodule

@@ hw/rtl/kcd_merge.sv @@
// Merging stage: picks the selected flag of the indexed lane.
module kcd_merge #(
  parameter int NUM_KEYS = kcd_pkg::NUM_KEYS_DEF
) (
  input  kcd_pkg::flags_t                  lane_flags [NUM_KEYS],
  input  logic                             check,
  input  logic [kcd_pkg::KEY_INDEX_W-1:0]  key_index,
  input  logic [kcd_pkg::FLAG_SEL_W-1:0]   flag_select,
  output logic                             hit
);
  import kcd_pkg::*;

  flags_t mask;

  assign mask = flag_mask(flag_select);

  // A key index without a lane matches nothing and so answers zero.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (check && int'(key_index) == k) begin
        hit = hit | (|(lane_flags[k] & mask));
      end
    end
  end

endmodule

@@ hw/rtl/key_click_detector.sv @@
// Top level of the key click detector: configuration, prescaler, key lanes and response register.
//
// Use: a beat on req is either a tick, which carries the pressed level of every key, or a
// check, which names one key and one flag. Every beat gives exactly one beat on rsp: a
// tick answers flag_hit 0, a check answers whether the selected flag was set, and clears
// it unless it is the hold flag. Every tick counts the press timers down; every
// sample_divider ticks the keys are sampled and each lane's click phase machine runs,
// raising sticky single, double, long and long-long flags.
// The response is registered and is shown in the cycle after the request beat.
// Throughput is one beat per cycle, set by the single response register, since every
// lane completes its update in the cycle of the beat.
// When the receiver stalls, the response register holds its beat and req.ready falls
// until that beat is taken; while rsp.ready is high a new request is taken every cycle.
// The configuration port writes one register at each clock edge at which cfg_write is
// high; it is meant to be used while the block is idle.
// Reset (synchronous, active high) clears the prescaler, all lane state and flags,
// empties the response register and returns the registers to their default values.
module key_click_detector #(
  parameter int NUM_KEYS = kcd_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  kcd_in_if.sink                            req,
  kcd_out_if.source                         rsp,
  input  logic                              cfg_write,
  input  logic [kcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [kcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import kcd_pkg::*;

  cfg_t             cfg;
  logic [DIV_W-1:0] prescale;
  logic [DIV_W-1:0] prescale_inc;
  logic             accept;
  logic             is_tick;
  logic             is_check;
  logic             sample;
  lane_ctrl_t       ctrl;
  flags_t           lane_flags [NUM_KEYS];
  logic             hit;
  logic             rsp_valid;
  logic             rsp_hit;

  // The response register parts the two sides: a request is taken whenever the
  // register is empty or its beat leaves in the same cycle.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_tick   = accept && (req.opcode == OP_TICK);
  assign is_check  = accept && (req.opcode == OP_CHECK);

  // Registers written by the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_divider   <= SAMPLE_DIVIDER_RST;
      cfg.long_press_ticks <= LONG_PRESS_TICKS_RST;
      cfg.double_gap_ticks <= DOUBLE_GAP_TICKS_RST;
      cfg.very_long_ticks  <= VERY_LONG_TICKS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_DIVIDER:   cfg.sample_divider   <= cfg_data[DIV_W-1:0];
        CFG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[TIMER_W-1:0];
        CFG_DOUBLE_GAP_TICKS: cfg.double_gap_ticks <= cfg_data[TIMER_W-1:0];
        CFG_VERY_LONG_TICKS:  cfg.very_long_ticks  <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tick prescaler. The count is eight bits wide and is compared with >=, so a divider of zero
  // samples on every tick, and a divider lowered below the count samples on the next tick.
  assign prescale_inc = prescale + DIV_W'(1);
  assign sample       = is_tick && (prescale_inc >= cfg.sample_divider);

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
    end else if (is_tick) begin
      prescale <= sample ? '0 : prescale_inc;
    end
  end

  assign ctrl.tick        = is_tick;
  assign ctrl.sample      = sample;
  assign ctrl.check       = is_check;
  assign ctrl.key_index   = req.key_index;
  assign ctrl.flag_select = req.flag_select;

  // One lane per key. Keys beyond the level bits of a tick always read released.
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    if (k < LEVEL_W) begin : g_level
      assign level = req.key_levels[k];
    end else begin : g_released
      assign level = 1'b0;
    end

    kcd_key_lane #(
      .LANE (k)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .cfg   (cfg),
      .level (level),
      .flags (lane_flags[k])
    );
  end

  // The merge reads the flags before this beat's clear lands in the lane.
  kcd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .lane_flags  (lane_flags),
    .check       (is_check),
    .key_index   (req.key_index),
    .flag_select (req.flag_select),
    .hit         (hit)
  );

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_hit <= hit;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.flag_hit = rsp_hit;

  a_beat_gives_response: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("request beat produced no response");

  a_tick_answers_zero: assert property (@(posedge clk) disable iff (rst)
    is_tick |=> !rsp_hit)
    else $error("tick beat answered a set flag");

  a_prescale_restarts: assert property (@(posedge clk) disable iff (rst)
    sample |=> prescale == '0)
    else $error("prescaler did not restart after a sample");

  a_stall_blocks_request: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |-> !accept)
    else $error("request taken while the response register was stalled");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for the key click detector: flag scoreboard class, driving tasks and top module.

class key_flag_scoreboard;
  logic [kcd_pkg::DIV_W-1:0]   divider;
  logic [kcd_pkg::TIMER_W-1:0] long_ticks;
  logic [kcd_pkg::TIMER_W-1:0] gap_ticks;
  logic [kcd_pkg::TIMER_W-1:0] very_long_ticks;

  logic [kcd_pkg::DIV_W-1:0]   prescale;
  logic                        level_now  [kcd_pkg::NUM_KEYS_DEF];
  logic                        level_last [kcd_pkg::NUM_KEYS_DEF];
  kcd_pkg::phase_t             phase      [kcd_pkg::NUM_KEYS_DEF];
  logic [kcd_pkg::TIMER_W-1:0] press_timer[kcd_pkg::NUM_KEYS_DEF];
  kcd_pkg::flags_t             flags      [kcd_pkg::NUM_KEYS_DEF];

  logic expected_hits[$];
  int   failures;

  function new();
    divider         = kcd_pkg::SAMPLE_DIVIDER_RST;
    long_ticks      = kcd_pkg::LONG_PRESS_TICKS_RST;
    gap_ticks       = kcd_pkg::DOUBLE_GAP_TICKS_RST;
    very_long_ticks = kcd_pkg::VERY_LONG_TICKS_RST;
    prescale        = '0;
    failures        = 0;
    for (int k = 0; k < kcd_pkg::NUM_KEYS_DEF; k++) begin
      level_now[k]   = 1'b0;
      level_last[k]  = 1'b0;
      phase[k]       = kcd_pkg::PH_IDLE;
      press_timer[k] = '0;
      flags[k]       = '0;
    end
  endfunction

  function void set_register(logic [kcd_pkg::CFG_INDEX_W-1:0] idx,
                             logic [kcd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      kcd_pkg::CFG_SAMPLE_DIVIDER:   divider = data[kcd_pkg::DIV_W-1:0];
      kcd_pkg::CFG_LONG_PRESS_TICKS: long_ticks = data;
      kcd_pkg::CFG_DOUBLE_GAP_TICKS: gap_ticks = data;
      default:                       very_long_ticks = data;
    endcase
  endfunction

  function int pending();
    return expected_hits.size();
  endfunction

  // Advances the key state by one accepted request beat and queues the flag_hit it should give.
  function void predict_hit(logic op, logic [kcd_pkg::LEVEL_W-1:0] levels,
                            logic [kcd_pkg::KEY_INDEX_W-1:0] key,
                            logic [kcd_pkg::FLAG_SEL_W-1:0] sel);
    logic down;
    logic hit;
    hit = 1'b0;
    if (op == kcd_pkg::OP_TICK) begin
      for (int k = 0; k < kcd_pkg::NUM_KEYS_DEF; k++) begin
        if (press_timer[k] != '0) press_timer[k] = press_timer[k] - 1'b1;
      end
      prescale = prescale + 1'b1;
      if (prescale >= divider) begin
        prescale = '0;
        for (int k = 0; k < kcd_pkg::NUM_KEYS_DEF; k++) begin
          down = (k < kcd_pkg::LEVEL_W) ? levels[k] : 1'b0;
          level_last[k] = level_now[k];
          level_now[k]  = down;
          flags[k][kcd_pkg::FLAG_HOLD] = down;
          if (down && !level_last[k]) flags[k][kcd_pkg::FLAG_DOWN] = 1'b1;
          if (!down && level_last[k]) flags[k][kcd_pkg::FLAG_UP] = 1'b1;
          case (phase[k])
            kcd_pkg::PH_IDLE: begin
              if (down) begin
                phase[k]       = kcd_pkg::PH_PRESSED;
                press_timer[k] = long_ticks;
              end
            end
            kcd_pkg::PH_PRESSED: begin
              if (!down) begin
                phase[k]       = kcd_pkg::PH_RELEASED;
                press_timer[k] = gap_ticks;
              end else if (press_timer[k] == '0) begin
                phase[k]       = kcd_pkg::PH_LONG;
                press_timer[k] = very_long_ticks;
              end
            end
            kcd_pkg::PH_RELEASED: begin
              if (down) begin
                flags[k][kcd_pkg::FLAG_DOUBLE] = 1'b1;
                phase[k] = kcd_pkg::PH_SECOND;
              end else if (press_timer[k] == '0) begin
                flags[k][kcd_pkg::FLAG_SINGLE] = 1'b1;
                phase[k] = kcd_pkg::PH_IDLE;
              end
            end
            kcd_pkg::PH_SECOND: begin
              if (!down) phase[k] = kcd_pkg::PH_IDLE;
            end
            kcd_pkg::PH_LONG: begin
              if (!down) begin
                flags[k][kcd_pkg::FLAG_LONG] = 1'b1;
                phase[k] = kcd_pkg::PH_IDLE;
              end else if (press_timer[k] == '0) begin
                flags[k][kcd_pkg::FLAG_LONG_LONG] = 1'b1;
              end
            end
            default: phase[k] = kcd_pkg::PH_IDLE;
          endcase
        end
      end
    end else if (int'(key) < kcd_pkg::NUM_KEYS_DEF && sel != kcd_pkg::FLAG_NONE) begin
      if (flags[key][sel]) begin
        hit = 1'b1;
        if (sel != kcd_pkg::FLAG_HOLD) flags[key][sel] = 1'b0;
      end
    end
    expected_hits.push_back(hit);
  endfunction

  function void compare_hit(logic actual);
    logic want;
    if (expected_hits.size() == 0) begin
      $error("flag_hit: response beat with nothing expected, actual %0b", actual);
      failures++;
    end else begin
      want = expected_hits.pop_front();
      if (actual !== want) begin
        $error("flag_hit mismatch: expected %0b, actual %0b", want, actual);
        failures++;
      end
    end
  endfunction
endclass

module tb;
  import kcd_pkg::*;

  // Each run programs one register setting and then sends a stretch of random beats.
  localparam int NUM_RUNS       = 8;
  localparam int RUN_ITEMS      = 156;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_RUN    = 6;

  // The settings run from the reset values through small fast timers to both extremes.
  localparam int RUN_DIVIDER   [NUM_RUNS] = '{20, 1, 0, 3, 255, 2, 1, 4};
  localparam int RUN_LONG      [NUM_RUNS] = '{2000, 8, 0, 20, 65535, 5, 3, 12};
  localparam int RUN_GAP       [NUM_RUNS] = '{200, 4, 0, 10, 65535, 3, 1, 6};
  localparam int RUN_VERY_LONG [NUM_RUNS] = '{100, 3, 0, 6, 65535, 2, 65535, 4};

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  kcd_in_if  req_if ();
  kcd_out_if rsp_if ();

  key_click_detector #(
    .NUM_KEYS (NUM_KEYS_DEF)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  key_flag_scoreboard flag_sb = new();

  // Idle percentages of the sender and the receiver; the stimulus changes them per run.
  int tx_idle_pct      = 16;
  int rx_idle_pct      = 50;
  int holdoff_requests = 0;
  int cycle_count      = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The receiver. Normally it drops ready at random; when the stimulus asks for a
  // hold-off it keeps ready low for a long stretch of its own counting, so that the
  // response register fills and the block has to stall its request channel.
  initial begin
    int holdoff_left;
    int holdoff_served;
    holdoff_left   = 0;
    holdoff_served = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        rsp_if.ready <= 1'b0;
        holdoff_left = holdoff_left - 1;
      end else if (holdoff_served != holdoff_requests) begin
        rsp_if.ready <= 1'b0;
        holdoff_left   = HOLDOFF_CYCLES;
        holdoff_served = holdoff_served + 1;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Both channels are observed at the clock edge, where the values seen are those from
  // before the edge's updates. An accepted request beat advances the prediction and an
  // accepted response beat is compared with the oldest expected flag_hit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        flag_sb.predict_hit(req_if.opcode, req_if.key_levels, req_if.key_index,
                            req_if.flag_select);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        flag_sb.compare_hit(rsp_if.flag_hit);
      end
    end
  end

  // Offers one request beat after a random number of idle cycles and returns at the edge
  // where it is taken. Valid is left high, so that the next beat can follow at once.
  task automatic send_beat(input logic op, input logic [LEVEL_W-1:0] levels,
                           input logic [KEY_INDEX_W-1:0] key,
                           input logic [FLAG_SEL_W-1:0] sel);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.opcode      <= op;
    req_if.key_levels  <= levels;
    req_if.key_index   <= key;
    req_if.flag_select <= sel;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  // The fields that a beat does not use carry random values, which the block must ignore.
  task automatic tick_beat(input logic [LEVEL_W-1:0] levels);
    send_beat(OP_TICK, levels, KEY_INDEX_W'($urandom), FLAG_SEL_W'($urandom));
  endtask

  task automatic check_beat(input logic [KEY_INDEX_W-1:0] key,
                            input logic [FLAG_SEL_W-1:0] sel);
    send_beat(OP_CHECK, LEVEL_W'($urandom), key, sel);
  endtask

  // The sender stops and waits until every expected response has been taken. Every
  // request gives a response, so the block is idle once nothing is expected.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (flag_sb.pending() != 0);
  endtask

  // Write enable stays high across consecutive writes; program_config lowers it.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    flag_sb.set_register(idx, data);
  endtask

  // The upper byte of the divider write is random: only the low eight bits count.
  task automatic program_config(input logic [DIV_W-1:0] div, input logic [TIMER_W-1:0] long_t,
                                input logic [TIMER_W-1:0] gap_t,
                                input logic [TIMER_W-1:0] very_long_t);
    write_register(CFG_SAMPLE_DIVIDER, {8'($urandom), div});
    write_register(CFG_LONG_PRESS_TICKS, long_t);
    write_register(CFG_DOUBLE_GAP_TICKS, gap_t);
    write_register(CFG_VERY_LONG_TICKS, very_long_t);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [LEVEL_W-1:0]     levels;
    logic [KEY_INDEX_W-1:0] key;
    int                     flip_odds;

    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= CFG_SAMPLE_DIVIDER;
    cfg_data           <= '0;
    req_if.valid       <= 1'b0;
    req_if.opcode      <= OP_TICK;
    req_if.key_levels  <= '0;
    req_if.key_index   <= '0;
    req_if.flag_select <= FLAG_HOLD;
    levels    = '0;
    flip_odds = 12;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // With the reset divider one tick does not yet sample, so the hold flag is still clear.
    tick_beat(3'b111);
    check_beat(2'd0, FLAG_HOLD);
    drain_responses();

    // A divider of zero samples on every tick, which keeps the directed sequences short.
    program_config(8'd0, 16'd2, 16'd2, 16'd1);

    // A long press on key 0 reaches the long phase; the long-long flag must come
    // back on every further sample while the key stays down, then release gives long.
    repeat (5) tick_beat(3'b001);
    check_beat(2'd0, FLAG_LONG_LONG);
    tick_beat(3'b001);
    check_beat(2'd0, FLAG_LONG_LONG);
    tick_beat(3'b000);
    check_beat(2'd0, FLAG_LONG);
    check_beat(2'd0, FLAG_LONG);
    check_beat(2'd0, FLAG_UP);
    check_beat(2'd0, FLAG_HOLD);

    // A short press followed by a gap that runs out gives a single click.
    tick_beat(3'b001);
    repeat (3) tick_beat(3'b000);
    check_beat(2'd0, FLAG_SINGLE);

    // Two presses on keys 0 and 2 within the gap give double clicks.
    tick_beat(3'b101);
    tick_beat(3'b000);
    tick_beat(3'b101);
    tick_beat(3'b000);
    check_beat(2'd2, FLAG_DOUBLE);

    // A key beyond the last one and the unused flag select both answer 0.
    check_beat(2'd3, FLAG_DOWN);
    check_beat(2'd1, FLAG_NONE);
    drain_responses();

    // Random runs. Key levels persist and flip with an odds that changes every forty
    // beats, so that presses and releases of every length occur and the phase machines
    // reach their deeper states; about three beats in ten are checks.
    for (int run = 0; run < NUM_RUNS; run++) begin
      program_config(DIV_W'(RUN_DIVIDER[run]), TIMER_W'(RUN_LONG[run]),
                     TIMER_W'(RUN_GAP[run]), TIMER_W'(RUN_VERY_LONG[run]));
      tx_idle_pct = (run < 3) ? 16 : (run < 6) ? 50 : 0;
      rx_idle_pct = (run < 3) ? 50 : (run < 6) ? 16 : 0;
      for (int n = 0; n < RUN_ITEMS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0:       flip_odds = 3;
            1:       flip_odds = 12;
            default: flip_odds = 40;
          endcase
        end
        if (run == HOLDOFF_RUN && n == 40) holdoff_requests = holdoff_requests + 1;
        if ($urandom_range(99) < 30) begin
          key = ($urandom_range(99) < 8) ? 2'd3 : KEY_INDEX_W'($urandom_range(NUM_KEYS_DEF - 1));
          check_beat(key, FLAG_SEL_W'($urandom_range(7)));
        end else begin
          for (int k = 0; k < LEVEL_W; k++) begin
            if ($urandom_range(flip_odds - 1) == 0) levels[k] = ~levels[k];
          end
          tick_beat(levels);
        end
      end
      drain_responses();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (flag_sb.pending() != 0) begin
      $error("flag_hit: %0d expected response beats never arrived", flag_sb.pending());
      flag_sb.failures++;
    end
    if (flag_sb.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // A run that hangs is ended here after far more cycles than a correct run needs.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/kcd_pkg.sv
hw/rtl/kcd_in_if.sv
hw/rtl/kcd_out_if.sv
hw/rtl/kcd_key_lane.sv
hw/rtl/kcd_merge.sv
hw/rtl/key_click_detector.sv
tb/sv/tb.sv
